// ----- hw/rtl/mmws_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and state encodings for the window smoother.
package mmws_pkg;

    localparam int MAX_HALF_DEF = 15;

    localparam int SAMPLE_W  = 24;
    localparam int SUM_W     = 29;
    localparam int FACTOR_W  = 16;
    localparam int HW_W      = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_MEAN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR     = 2'd2;

    localparam logic                MODE_MEAN_RST  = 1'b1;
    localparam logic [HW_W-1:0]     HALF_WIDTH_RST = 4'd1;
    localparam logic [FACTOR_W-1:0] FACTOR_RST     = 16'd21845;

    localparam logic signed [SAMPLE_W-1:0] VALUE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] VALUE_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } smp_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       run_last;
        logic                       series_done;
        logic                       too_short;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_RANK,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        RK_IDLE,
        RK_CAND,
        RK_LOAD,
        RK_SCAN,
        RK_CHECK
    } rank_state_t;

endpackage

// ----- hw/rtl/mmws_window_mem.sv -----
`timescale 1ns / 1ps
// Circular sample store: one write port, one registered read port, per-entry valid bits.
module mmws_window_mem #(
    parameter int MAX_HALF = mmws_pkg::MAX_HALF_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 we,
    input  logic [$clog2(2*MAX_HALF+1)-1:0]      waddr,
    input  logic signed [mmws_pkg::SAMPLE_W-1:0] wdata,
    input  logic [$clog2(2*MAX_HALF+1)-1:0]      raddr,
    output logic signed [mmws_pkg::SAMPLE_W-1:0] rdata
);

    localparam int WIN_MAX = 2 * MAX_HALF + 1;

    logic signed [mmws_pkg::SAMPLE_W-1:0] mem [WIN_MAX];
    logic [WIN_MAX-1:0]                   valid_reg;
    logic signed [mmws_pkg::SAMPLE_W-1:0] mem_q_reg;
    logic                                 vld_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[raddr];
        vld_q_reg <= valid_reg[raddr];
    end

    // never-written entries read as zero
    assign rdata = vld_q_reg ? mem_q_reg : '0;

endmodule

// ----- hw/rtl/mmws_mean_unit.sv -----
`timescale 1ns / 1ps
// Mean path: window sum times Q0.16 factor, floored and saturated to 24 bits.
module mmws_mean_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [mmws_pkg::SUM_W-1:0]    sum,
    input  logic [mmws_pkg::FACTOR_W-1:0]        factor,
    output logic                                 done,
    output logic signed [mmws_pkg::SAMPLE_W-1:0] value
);

    localparam int PROD_W = mmws_pkg::SUM_W + mmws_pkg::FACTOR_W + 1;
    localparam int SHR_W  = PROD_W - mmws_pkg::FACTOR_W;

    logic signed [PROD_W-1:0]             prod_next;
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [SHR_W-1:0]              shr;
    logic                                 fits;
    logic signed [mmws_pkg::SAMPLE_W-1:0] sat;
    logic signed [mmws_pkg::SAMPLE_W-1:0] value_reg;
    logic                                 s1_reg;
    logic                                 s2_reg;

    assign prod_next = sum * $signed({1'b0, factor});

    // arithmetic shift gives the floor
    assign shr  = SHR_W'(prod_reg >>> mmws_pkg::FACTOR_W);
    assign fits = (shr[SHR_W-1:mmws_pkg::SAMPLE_W-1] == '0)
               || (shr[SHR_W-1:mmws_pkg::SAMPLE_W-1] == '1);
    assign sat  = fits ? shr[mmws_pkg::SAMPLE_W-1:0]
                : (shr[SHR_W-1] ? mmws_pkg::VALUE_MIN : mmws_pkg::VALUE_MAX);

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        value_reg <= sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= start;
            s2_reg <= s1_reg;
        end
    end

    assign done  = s2_reg;
    assign value = value_reg;

endmodule

// ----- hw/rtl/mmws_rank_unit.sv -----
`timescale 1ns / 1ps
// Median by counting: one shared comparator ranks each candidate against the window.
module mmws_rank_unit #(
    parameter int MAX_HALF = mmws_pkg::MAX_HALF_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [$clog2(2*MAX_HALF+2)-1:0]      len,
    input  logic [mmws_pkg::HW_W-1:0]            rank,
    input  logic signed [mmws_pkg::SAMPLE_W-1:0] rd_data,
    output logic [$clog2(2*MAX_HALF+1)-1:0]      rd_idx,
    output logic                                 done,
    output logic signed [mmws_pkg::SAMPLE_W-1:0] value
);

    localparam int WIN_MAX = 2 * MAX_HALF + 1;
    localparam int PTR_W   = $clog2(WIN_MAX);
    localparam int CNT_W   = $clog2(WIN_MAX + 1);

    mmws_pkg::rank_state_t state_reg, state_next;

    logic [PTR_W-1:0]                     i_reg, i_next;
    logic [PTR_W-1:0]                     cnt_reg, cnt_next;
    logic [CNT_W-1:0]                     less_reg, less_next;
    logic [CNT_W-1:0]                     eq_reg, eq_next;
    logic signed [mmws_pkg::SAMPLE_W-1:0] cand_reg, cand_next;

    logic [PTR_W-1:0] last_idx;
    logic [CNT_W-1:0] rank_w;
    logic             is_less;
    logic             is_eq;
    logic             hit;

    assign last_idx = PTR_W'(len - CNT_W'(1));
    assign rank_w   = CNT_W'(rank);
    assign is_less  = rd_data < cand_reg;
    assign is_eq    = rd_data == cand_reg;
    assign hit      = (less_reg <= rank_w) && (rank_w < less_reg + eq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mmws_pkg::RK_IDLE;
            i_reg     <= '0;
            cnt_reg   <= '0;
            less_reg  <= '0;
            eq_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            cnt_reg   <= cnt_next;
            less_reg  <= less_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        cnt_next   = cnt_reg;
        less_next  = less_reg;
        eq_next    = eq_reg;
        cand_next  = cand_reg;
        rd_idx     = '0;
        done       = 1'b0;
        case (state_reg)
            mmws_pkg::RK_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    state_next = mmws_pkg::RK_CAND;
                end
            end
            mmws_pkg::RK_CAND:
            begin
                rd_idx     = i_reg;
                state_next = mmws_pkg::RK_LOAD;
            end
            mmws_pkg::RK_LOAD:
            begin
                // candidate arrives; first scan read goes out now
                cand_next  = rd_data;
                rd_idx     = '0;
                cnt_next   = '0;
                less_next  = '0;
                eq_next    = '0;
                state_next = mmws_pkg::RK_SCAN;
            end
            mmws_pkg::RK_SCAN:
            begin
                if (is_less)
                begin
                    less_next = less_reg + CNT_W'(1);
                end
                else if (is_eq)
                begin
                    eq_next = eq_reg + CNT_W'(1);
                end
                if (cnt_reg == last_idx)
                begin
                    state_next = mmws_pkg::RK_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + PTR_W'(1);
                    rd_idx   = cnt_reg + PTR_W'(1);
                end
            end
            mmws_pkg::RK_CHECK:
            begin
                if (hit)
                begin
                    done       = 1'b1;
                    state_next = mmws_pkg::RK_IDLE;
                end
                else
                begin
                    i_next     = i_reg + PTR_W'(1);
                    state_next = mmws_pkg::RK_CAND;
                end
            end
            default:
            begin
                state_next = mmws_pkg::RK_IDLE;
            end
        endcase
    end

    assign value = cand_reg;

endmodule

// ----- hw/rtl/mean_median_window_smoother.sv -----
`timescale 1ns / 1ps
// Centred-window smoother (moving mean or running median) with a sequenced datapath.
//
// One request is taken at a time; smp_stall goes high after acceptance and stays high until
// the last result of that request has been loaded into the output register, or until the
// window has been updated when the request gives no result. Each request is accepted,
// updates the window, then computes the result: mean mode uses the two-stage multiplier,
// median mode has the single shared comparator rank c candidates (c is 1 to L, where
// L = 2*half_width+1) against the window, one window read per cycle, until it finds the
// middle one. Each result then passes through the output register, and up to L copies
// are produced when the window first fills or the series ends.
// The window memory needs no clearing pass: per-entry valid bits are cleared by reset.
module mean_median_window_smoother #(
    parameter int MAX_HALF = mmws_pkg::MAX_HALF_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               smp_valid,
    output logic                               smp_stall,
    input  mmws_pkg::smp_t                     smp,
    output logic                               res_valid,
    input  logic                               res_stall,
    output mmws_pkg::res_t                     res,
    input  logic                               cfg_we,
    input  logic [mmws_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmws_pkg::CFG_W-1:0]         cfg_data
);

    localparam int WIN_MAX = 2 * MAX_HALF + 1;
    localparam int PTR_W   = $clog2(WIN_MAX);
    localparam int CNT_W   = $clog2(WIN_MAX + 1);
    localparam int SW      = mmws_pkg::SAMPLE_W;
    localparam int HW_W    = mmws_pkg::HW_W;

    mmws_pkg::ctl_state_t state_reg, state_next;

    logic                               mode_reg, mode_next;
    logic [HW_W-1:0]                    hw_reg, hw_next;
    logic [mmws_pkg::FACTOR_W-1:0]      factor_reg, factor_next;
    logic [PTR_W-1:0]                   wp_reg, wp_next;
    logic [CNT_W-1:0]                   fill_reg, fill_next;
    logic signed [mmws_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]                   rem_reg, rem_next;
    logic                               kick_reg, kick_next;
    logic                               short_reg, short_next;
    logic                               last_reg, last_next;
    logic                               res_valid_reg, res_valid_next;
    logic signed [SW-1:0]               sample_reg, sample_next;
    logic signed [SW-1:0]               result_reg, result_next;
    mmws_pkg::res_t                     res_reg, res_next;

    logic [CNT_W-1:0]                   len;
    logic [CNT_W-1:0]                   hw_c;
    logic [CNT_W-1:0]                   reps;
    logic                               full;
    logic                               just_filled;
    logic [PTR_W-1:0]                   wp_new;
    logic [PTR_W-1:0]                   rd_k;
    logic [PTR_W:0]                     wp_x;
    logic [PTR_W:0]                     k_x;
    logic [PTR_W-1:0]                   rd_addr;
    logic signed [SW-1:0]               rd_data;
    logic signed [mmws_pkg::SUM_W-1:0]  sum_calc;
    logic                               mem_we;
    logic                               out_free;
    logic [HW_W-1:0]                    hw_wr;
    logic [HW_W-1:0]                    hw_clamp;

    logic                               mean_start;
    logic                               mean_done;
    logic signed [SW-1:0]               mean_value;
    logic                               rank_start;
    logic                               rank_done;
    logic signed [SW-1:0]               rank_value;
    logic [PTR_W-1:0]                   rank_idx;

    assign len         = CNT_W'({hw_reg, 1'b1});
    assign hw_c        = CNT_W'(hw_reg);
    assign full        = fill_reg >= len;
    assign just_filled = (fill_reg + CNT_W'(1)) == len;
    assign reps        = CNT_W'(1) + (just_filled ? hw_c : '0) + (last_reg ? hw_c : '0);
    assign wp_new      = (wp_reg == PTR_W'(WIN_MAX - 1)) ? '0 : wp_reg + PTR_W'(1);

    // logical index k (0 = newest) maps to wp - k, modulo the depth
    assign rd_k    = (state_reg == mmws_pkg::ST_RANK) ? rank_idx : PTR_W'(len - CNT_W'(1));
    assign wp_x    = {1'b0, wp_reg};
    assign k_x     = {1'b0, rd_k};
    assign rd_addr = PTR_W'((wp_x >= k_x) ? wp_x - k_x
                            : wp_x + (PTR_W + 1)'(WIN_MAX) - k_x);

    assign sum_calc = sum_reg - (full ? mmws_pkg::SUM_W'(rd_data) : '0)
                    + mmws_pkg::SUM_W'(sample_reg);

    assign out_free   = !res_valid_reg || !res_stall;
    assign mean_start = kick_reg && (state_reg == mmws_pkg::ST_MEAN);
    assign rank_start = kick_reg && (state_reg == mmws_pkg::ST_RANK);

    assign hw_wr    = cfg_data[HW_W-1:0];
    assign hw_clamp = (int'(hw_wr) > MAX_HALF) ? HW_W'(MAX_HALF) : hw_wr;

    mmws_window_mem #(
        .MAX_HALF (MAX_HALF)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (wp_new),
        .wdata (sample_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mmws_mean_unit u_mean (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mean_start),
        .sum    (sum_reg),
        .factor (factor_reg),
        .done   (mean_done),
        .value  (mean_value)
    );

    mmws_rank_unit #(
        .MAX_HALF (MAX_HALF)
    ) u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rank_start),
        .len     (len),
        .rank    (hw_reg),
        .rd_data (rd_data),
        .rd_idx  (rank_idx),
        .done    (rank_done),
        .value   (rank_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mmws_pkg::ST_IDLE;
            mode_reg      <= mmws_pkg::MODE_MEAN_RST;
            hw_reg        <= mmws_pkg::HALF_WIDTH_RST;
            factor_reg    <= mmws_pkg::FACTOR_RST;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            rem_reg       <= '0;
            kick_reg      <= 1'b0;
            short_reg     <= 1'b0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            hw_reg        <= hw_next;
            factor_reg    <= factor_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            rem_reg       <= rem_next;
            kick_reg      <= kick_next;
            short_reg     <= short_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        result_reg <= result_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        hw_next        = hw_reg;
        factor_next    = factor_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        kick_next      = 1'b0;
        short_next     = short_reg;
        last_next      = last_reg;
        sample_next    = sample_reg;
        result_next    = result_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        mem_we         = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            mmws_pkg::ST_IDLE:
            begin
                // oldest-sample read is issued here every cycle
                if (smp_valid)
                begin
                    sample_next = smp.sample;
                    last_next   = smp.last;
                    state_next  = mmws_pkg::ST_SUM;
                end
            end
            mmws_pkg::ST_SUM:
            begin
                mem_we    = 1'b1;
                wp_next   = wp_new;
                sum_next  = sum_calc;
                fill_next = full ? fill_reg : fill_reg + CNT_W'(1);
                if (!full && !just_filled)
                begin
                    if (last_reg)
                    begin
                        result_next = '0;
                        short_next  = 1'b1;
                        rem_next    = CNT_W'(1);
                        state_next  = mmws_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = mmws_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    short_next = 1'b0;
                    rem_next   = reps;
                    kick_next  = 1'b1;
                    state_next = mode_reg ? mmws_pkg::ST_MEAN : mmws_pkg::ST_RANK;
                end
            end
            mmws_pkg::ST_MEAN:
            begin
                if (mean_done)
                begin
                    result_next = mean_value;
                    state_next  = mmws_pkg::ST_EMIT;
                end
            end
            mmws_pkg::ST_RANK:
            begin
                if (rank_done)
                begin
                    result_next = rank_value;
                    state_next  = mmws_pkg::ST_EMIT;
                end
            end
            mmws_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    res_next.value       = result_reg;
                    res_next.run_last    = rem_reg == CNT_W'(1);
                    res_next.series_done = (rem_reg == CNT_W'(1)) && last_reg;
                    res_next.too_short   = short_reg;
                    res_valid_next       = 1'b1;
                    rem_next             = rem_reg - CNT_W'(1);
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = mmws_pkg::ST_IDLE;
                        if (last_reg)
                        begin
                            fill_next = '0;
                            sum_next  = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = mmws_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                mmws_pkg::CFG_MODE_MEAN:
                begin
                    mode_next = cfg_data[0];
                end
                mmws_pkg::CFG_HALF_WIDTH:
                begin
                    // new width starts a new series
                    hw_next   = hw_clamp;
                    fill_next = '0;
                    sum_next  = '0;
                end
                mmws_pkg::CFG_FACTOR:
                begin
                    factor_next = cfg_data[mmws_pkg::FACTOR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign smp_stall = state_reg != mmws_pkg::ST_IDLE;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- hw/rtl/mmws_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the window smoother, bound to the top level.
module mmws_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           smp_valid,
    input logic           smp_stall,
    input logic           res_valid,
    input logic           res_stall,
    input mmws_pkg::res_t res
);

    a_res_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result request dropped while stalled");

    a_res_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("result payload changed while stalled");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |=> smp_stall)
        else $error("input not stalled while a request is in work");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.series_done |-> res.run_last)
        else $error("series end flagged on a result that is not the last of its request");

    a_short_form: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.too_short |-> res.run_last && res.series_done && (res.value == '0))
        else $error("short-series result malformed");

endmodule

bind mean_median_window_smoother mmws_checker u_mmws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the mean/median window smoother.
module testbench;

    localparam int CLK_PERIOD      = 2;
    localparam int RESET_CYCLES    = 7;
    localparam int WIN_MAX         = 2 * mmws_pkg::MAX_HALF_DEF + 1;
    localparam int RANDOM_ITEMS    = 220;
    localparam int IDLE_PAUSE      = 1200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 8_000_000;

    localparam logic MODE_MEDIAN = 1'b0;
    localparam logic MODE_MEAN   = 1'b1;

    typedef logic [mmws_pkg::CFG_W-1:0]             cfg_word_t;
    typedef logic [mmws_pkg::CFG_IDX_W-1:0]         cfg_idx_t;
    typedef logic [mmws_pkg::HW_W-1:0]              half_t;
    typedef logic signed [mmws_pkg::SAMPLE_W-1:0]   sample_t;

    typedef struct {
        bit             is_cfg;
        cfg_idx_t       idx;
        cfg_word_t      data;
        mmws_pkg::smp_t item;
        bit             typed;
        mmws_pkg::res_t want;
    } stim_row_t;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           smp_valid;
    logic           smp_stall;
    mmws_pkg::smp_t smp;
    logic           res_valid;
    logic           res_stall;
    mmws_pkg::res_t res;
    logic           cfg_we;
    cfg_idx_t       cfg_index;
    cfg_word_t      cfg_data;

    // predictor state
    logic                                 cur_mode_mean;
    half_t                                cur_half;
    logic [mmws_pkg::FACTOR_W-1:0]        cur_factor;
    sample_t                              win_store [WIN_MAX];
    logic signed [mmws_pkg::SUM_W-1:0]    win_sum;
    int unsigned                          win_fill;

    mmws_pkg::res_t step_results [$];
    mmws_pkg::res_t pending_smoothed [$];
    stim_row_t      directed_rows [$];
    int unsigned    fault_count = 0;
    int unsigned    burst_left = 0;
    int unsigned    random_sent = 0;
    bit             hold_off_req = 1'b0;
    bit             hold_off_done;

    mean_median_window_smoother i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp_valid  (smp_valid),
        .smp_stall  (smp_stall),
        .smp        (smp),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic sample_t window_mean();
        longint scaled;
        scaled = (longint'(win_sum) * longint'(cur_factor)) >>> 16;
        if (scaled > mmws_pkg::VALUE_MAX)
            return mmws_pkg::VALUE_MAX;
        if (scaled < mmws_pkg::VALUE_MIN)
            return mmws_pkg::VALUE_MIN;
        return scaled[mmws_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic sample_t window_median(input int unsigned len, input int unsigned rank);
        int unsigned below;
        int unsigned same;
        for (int i = 0; i < len; i++)
        begin
            below = 0;
            same  = 0;
            for (int j = 0; j < len; j++)
            begin
                if (win_store[j] < win_store[i])
                    below++;
                else if (win_store[j] == win_store[i])
                    same++;
            end
            if (below <= rank && rank < below + same)
                return win_store[i];
        end
        return win_store[0];
    endfunction

    // Shift one sample into the window and work out the results it causes.
    function automatic void smooth_step(input mmws_pkg::smp_t item);
        int unsigned    len;
        int unsigned    reps;
        bit             filled_now;
        sample_t        level;
        mmws_pkg::res_t one;
        step_results.delete();
        len = 2 * cur_half + 1;
        if (win_fill >= len)
            win_sum -= win_store[len - 1];
        for (int i = WIN_MAX - 1; i > 0; i--)
            win_store[i] = win_store[i - 1];
        win_store[0] = item.sample;
        win_sum += item.sample;
        filled_now = (win_fill + 1 == len);
        if (win_fill < len)
            win_fill++;
        if (win_fill < len)
        begin
            if (item.last)
            begin
                one.value       = '0;
                one.run_last    = 1'b1;
                one.series_done = 1'b1;
                one.too_short   = 1'b1;
                step_results.push_back(one);
                win_sum  = '0;
                win_fill = 0;
            end
            return;
        end
        level = cur_mode_mean ? window_mean() : window_median(len, cur_half);
        reps = 1 + (filled_now ? cur_half : 0) + (item.last ? cur_half : 0);
        for (int k = 0; k < reps; k++)
        begin
            one.value       = level;
            one.run_last    = (k + 1 == reps);
            one.series_done = item.last && (k + 1 == reps);
            one.too_short   = 1'b0;
            step_results.push_back(one);
        end
        if (item.last)
        begin
            win_sum  = '0;
            win_fill = 0;
        end
    endfunction

    function automatic stim_row_t cfg_row(input cfg_idx_t idx, input cfg_word_t data);
        stim_row_t row;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        row.item   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic stim_row_t sample_row(input sample_t sample, input logic last);
        stim_row_t row;
        row.is_cfg      = 1'b0;
        row.idx         = mmws_pkg::CFG_MODE_MEAN;
        row.data        = '0;
        row.item.sample = sample;
        row.item.last   = last;
        row.typed       = 1'b0;
        row.want        = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(input sample_t sample,
                                            input logic    last,
                                            input sample_t value,
                                            input logic    run_last,
                                            input logic    series_done,
                                            input logic    too_short);
        stim_row_t row;
        row = sample_row(sample, last);
        row.typed            = 1'b1;
        row.want.value       = value;
        row.want.run_last    = run_last;
        row.want.series_done = series_done;
        row.want.too_short   = too_short;
        return row;
    endfunction

    function automatic sample_t pick_sample();
        logic [31:0] raw;
        case ($urandom_range(0, 7))
            0: raw = 32'(mmws_pkg::VALUE_MAX);
            1: raw = 32'(mmws_pkg::VALUE_MIN);
            // narrow range, so median windows see ties
            2, 3: raw = $urandom_range(0, 20) - 10;
            default: raw = $urandom();
        endcase
        return raw[mmws_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic note_failure(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // One write, with cfg_we dropped again before the next write, so back-to-back writes never collide.
    task automatic write_cfg(input cfg_idx_t idx, input cfg_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mmws_pkg::CFG_MODE_MEAN: cur_mode_mean = data[0];
            mmws_pkg::CFG_HALF_WIDTH:
            begin
                cur_half = data[mmws_pkg::HW_W-1:0];
                win_sum  = '0;
                win_fill = 0;
            end
            mmws_pkg::CFG_FACTOR: cur_factor = data[mmws_pkg::FACTOR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one request; bursts of random length with random gaps in between.
    task automatic offer_sample(input mmws_pkg::smp_t item, input bit typed,
                                input mmws_pkg::res_t typed_result);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0)
            begin
                smp_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        smp       <= item;
        smp_valid <= 1'b1;
        do
            @(posedge clk);
        while (smp_stall);
        smooth_step(item);
        if (typed)
            pending_smoothed.push_back(typed_result);
        else
            foreach (step_results[k])
                pending_smoothed.push_back(step_results[k]);
    endtask

    task automatic send_series(input int unsigned count, input bit close_series);
        mmws_pkg::smp_t item;
        for (int n = 0; n < count; n++)
        begin
            item.sample = pick_sample();
            item.last   = close_series && (n + 1 == count);
            offer_sample(item, 1'b0, '0);
            random_sent++;
        end
    endtask

    // Drain everything, then allow for a request still being worked on with no result.
    task automatic wait_idle();
        if (smp_valid)
            smp_valid <= 1'b0;
        burst_left = 0;
        while (pending_smoothed.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        mmws_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_smoothed.size() == 0)
                note_failure($sformatf("unexpected result value=%0d run_last=%b done=%b short=%b",
                                       $signed(res.value), res.run_last, res.series_done,
                                       res.too_short));
            else
            begin
                want = pending_smoothed.pop_front();
                if (res.value !== want.value || res.run_last !== want.run_last ||
                    res.series_done !== want.series_done || res.too_short !== want.too_short)
                    note_failure($sformatf({"mismatch: expected value=%0d run_last=%b done=%b ",
                                            "short=%b, got value=%0d run_last=%b done=%b short=%b"},
                                           $signed(want.value), want.run_last, want.series_done,
                                           want.too_short, $signed(res.value), res.run_last,
                                           res.series_done, res.too_short));
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial
    begin
        int unsigned stretch;
        int unsigned pattern;
        res_stall     = 1'b0;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                stretch = $urandom_range(4, 60);
                pattern = $urandom_range(0, 3);
                repeat (stretch)
                begin
                    // start the hold-off at once when asked
                    if (hold_off_req && !hold_off_done)
                        break;
                    case (pattern)
                        0: res_stall <= 1'b0;
                        1: res_stall <= ($urandom_range(0, 1) == 0);
                        2: res_stall <= ($urandom_range(0, 4) == 0);
                        default: res_stall <= ($urandom_range(0, 4) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        stim_row_t      row;
        int unsigned    phase_no;
        int unsigned    half;
        int unsigned    win_len;
        int unsigned    series_count;
        int unsigned    kind;
        logic           mode;
        cfg_word_t      scale;
        cfg_word_t      cfg_bits;

        rst_n     = 1'b0;
        smp_valid = 1'b0;
        smp       = '0;
        cfg_we    = 1'b0;
        cfg_index = mmws_pkg::CFG_MODE_MEAN;
        cfg_data  = '0;

        cur_mode_mean = mmws_pkg::MODE_MEAN_RST;
        cur_half      = mmws_pkg::HALF_WIDTH_RST;
        cur_factor    = mmws_pkg::FACTOR_RST;
        foreach (win_store[i])
            win_store[i] = '0;
        win_sum  = '0;
        win_fill = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // from reset: mean, half width 1, factor about one third
        directed_rows.push_back(known_row(0, 1'b1, 0, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(sample_row(3, 1'b0));
        directed_rows.push_back(sample_row(6, 1'b0));
        directed_rows.push_back(sample_row(9, 1'b0));
        directed_rows.push_back(sample_row(-12, 1'b1));
        // single-sample window, full scale: one result per request
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_HALF_WIDTH, 0));
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_FACTOR, 16'hFFFF));
        directed_rows.push_back(known_row(mmws_pkg::VALUE_MAX, 1'b0, 8388479,
                                          1'b1, 1'b0, 1'b0));
        directed_rows.push_back(known_row(mmws_pkg::VALUE_MIN, 1'b0, -8388480,
                                          1'b1, 1'b0, 1'b0));
        directed_rows.push_back(known_row(-1, 1'b0, -1, 1'b1, 1'b0, 1'b0));
        directed_rows.push_back(known_row(1, 1'b1, 0, 1'b1, 1'b1, 1'b0));
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_FACTOR, 0));
        directed_rows.push_back(known_row(mmws_pkg::VALUE_MAX, 1'b0, 0, 1'b1, 1'b0, 1'b0));
        // median over five, with extremes and ties
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_MODE_MEAN, cfg_word_t'(MODE_MEDIAN)));
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_HALF_WIDTH, 2));
        directed_rows.push_back(sample_row(5, 1'b0));
        directed_rows.push_back(sample_row(-3, 1'b0));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MAX, 1'b0));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MIN, 1'b0));
        directed_rows.push_back(sample_row(0, 1'b0));
        directed_rows.push_back(sample_row(0, 1'b1));
        directed_rows.push_back(known_row(100, 1'b1, 0, 1'b1, 1'b1, 1'b1));
        // saturation both ways; last on the filling sample
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_MODE_MEAN, cfg_word_t'(MODE_MEAN)));
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_HALF_WIDTH, 1));
        directed_rows.push_back(cfg_row(mmws_pkg::CFG_FACTOR, 16'hFFFF));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MAX, 1'b0));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MAX, 1'b0));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MAX, 1'b1));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MIN, 1'b0));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MIN, 1'b0));
        directed_rows.push_back(sample_row(mmws_pkg::VALUE_MIN, 1'b1));

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                wait_idle();
                write_cfg(row.idx, row.data);
            end
            else
                offer_sample(row.item, row.typed, row.want);
        end

        phase_no = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            phase_no++;
            if (phase_no == 2)
                hold_off_req = 1'b1;
            if (phase_no == 1 || phase_no == 3)
                half = mmws_pkg::MAX_HALF_DEF;
            else if ($urandom_range(0, 9) == 0)
                half = $urandom_range(4, mmws_pkg::MAX_HALF_DEF - 1);
            else
                half = $urandom_range(0, 3);
            if (phase_no == 1)
                mode = MODE_MEAN;
            else if (phase_no == 3)
                mode = MODE_MEDIAN;
            else
                mode = 1'($urandom_range(0, 1));
            win_len = 2 * half + 1;
            case ($urandom_range(0, 5))
                0: scale = cfg_word_t'($urandom());
                1: scale = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default: scale = (win_len == 1) ? 16'hFFFF : cfg_word_t'(65536 / win_len);
            endcase

            // unused upper data bits are set now and then
            cfg_bits = ($urandom_range(0, 3) == 0) ? cfg_word_t'($urandom()) : '0;
            cfg_bits[0] = mode;
            write_cfg(mmws_pkg::CFG_MODE_MEAN, cfg_bits);
            cfg_bits = ($urandom_range(0, 3) == 0) ? cfg_word_t'($urandom()) : '0;
            cfg_bits[mmws_pkg::HW_W-1:0] = half_t'(half);
            write_cfg(mmws_pkg::CFG_HALF_WIDTH, cfg_bits);
            write_cfg(mmws_pkg::CFG_FACTOR, scale);

            series_count = (half >= 4) ? 1 : $urandom_range(1, 3);
            repeat (series_count)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0 && win_len > 1)
                    send_series($urandom_range(1, win_len - 1), 1'b1);
                else if (kind == 1)
                    // left open: the next series carries on from it
                    send_series($urandom_range(1, win_len + 4), 1'b0);
                else if (kind == 2)
                begin
                    send_series(win_len + $urandom_range(0, 3), 1'b0);
                    wait_idle();
                    if ($urandom_range(0, 1))
                        write_cfg(mmws_pkg::CFG_FACTOR, cfg_word_t'($urandom()));
                    else
                        write_cfg(mmws_pkg::CFG_MODE_MEAN, cfg_word_t'(!cur_mode_mean));
                    send_series($urandom_range(1, 8), 1'b1);
                end
                else
                    send_series(win_len + $urandom_range(0, 12), 1'b1);
            end
        end

        wait_idle();
        if (fault_count == 0 && pending_smoothed.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
